/* src/alts_pkg.sv */
// Shared constants and codes for the allocation tracker with leak scan.
package alts_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int WALK_W        = $clog2(TABLE_ENTRIES + 1);
    localparam int LIVE_W        = $clog2(TABLE_ENTRIES + 1);

    // Field widths
    localparam int OP_W     = 2;
    localparam int WORD_W   = 32;
    localparam int CNT_OUT_W = 7;
    localparam int ENTRY_W  = 3 * WORD_W;

    // Port widths
    localparam int S_DATA_W = 96;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 56;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Reset value of the leak age limit in ms
    localparam logic [WORD_W-1:0] AGE_LIMIT_RESET = 32'd30000;

    // Operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_SCAN    = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AGE_LIMIT = 1'd0,
        REG_TRACKING  = 1'd1
    } cfg_reg_t;

endpackage

/* src/allocation_tracker_leak_scan.sv */
// Allocation tracker: record table in a synchronous memory, walked once per allocation, release or scan.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready. s_tuser carries the operation
//   (allocate, release, scan, clear); s_tdata carries handle, size and time.
//   Every input word yields exactly one result word on m_tvalid/m_tready.
//   Register writes come on cfg_valid/cfg_ready with cfg_index and cfg_data;
//   they are taken at any time and should be made while the block is idle.
// Timing:
//   Allocations, releases and scans walk the record memory one entry per
//   cycle through its single read port; the next word is accepted only
//   after the walk is over and its result is in the output register.
//   Ignored words and clears skip the walk and go straight to the finish state.
// Reset:
//   All records are marked free, the live count is zero and the table is
//   not yet enabled; a first clear enables it. The age limit resets to
//   30000 ms and tracking to on. There is no clearing pass.
// Stalls:
//   A finished result sits in the output register; the block holds its
//   next result until the previous one is taken, and takes a new input
//   word as soon as it is back in its idle state.
module allocation_tracker_leak_scan (
    input  logic                             clk,
    input  logic                             rst_n,
    // fields from bit 0: handle[31:0], alloc_bytes[63:32], now_ms[95:64]
    input  logic [alts_pkg::S_DATA_W-1:0]    s_tdata,
    // fields from bit 0: operation[1:0]
    input  logic [alts_pkg::S_USER_W-1:0]    s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: accepted[0], evicted[1], found[2], live_records[9:3],
    // leak_count[16:10], leak_bytes[48:17], zero pad[55:49]
    output logic [alts_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [alts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [alts_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import alts_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        K_IGNORE,
        K_CLEAR,
        K_ALLOC,
        K_RELEASE,
        K_SCAN
    } kind_t;

    // Control state
    state_t                  state_reg;
    kind_t                   kind_reg;
    kind_t                   kind_next;
    logic [WALK_W-1:0]       walk_cnt_reg;
    logic                    rd_pend_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [LIVE_W-1:0]       live_reg;
    logic                    table_ready_reg;
    logic                    tracking_reg;
    logic [WORD_W-1:0]       age_limit_reg;

    // Walk results
    logic                    free_found_reg;
    logic [IDX_W-1:0]        free_idx_reg;
    logic                    best_vld_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [WORD_W-1:0]       best_stamp_reg;
    logic                    match_found_reg;
    logic [IDX_W-1:0]        match_idx_reg;
    logic [CNT_OUT_W-1:0]    leak_cnt_reg;
    logic [WORD_W-1:0]       leak_sum_reg;

    // Output register
    logic                    out_valid_reg;
    logic [M_DATA_W-1:0]     out_data_reg;

    // Payload of the current word
    logic [WORD_W-1:0]       handle_reg;
    logic [WORD_W-1:0]       bytes_reg;
    logic [WORD_W-1:0]       now_reg;

    // Record memory: {stamp, bytes, handle}
    logic [ENTRY_W-1:0]      entry_mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0]      rd_data_reg;

    logic                    in_fire;
    logic                    finish_fire;
    logic                    walk_issue;
    logic                    walk_done;
    logic                    active;
    op_t                     in_op;
    logic [WORD_W-1:0]       in_handle;
    logic [WORD_W-1:0]       rd_handle;
    logic [WORD_W-1:0]       rd_bytes;
    logic [WORD_W-1:0]       rd_stamp;
    logic                    rd_valid;
    logic [WORD_W-1:0]       rd_age;
    logic [WORD_W:0]         sum_wide;
    logic [IDX_W-1:0]        wr_slot;
    logic                    mem_we;

    // Handshake decode
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_fire     = s_tvalid && s_tready;
    assign cfg_ready   = 1'b1;
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = out_data_reg;
    assign finish_fire = (state_reg == ST_FINISH) && (!out_valid_reg || m_tready);
    assign walk_issue  = (state_reg == ST_WALK) && (walk_cnt_reg != WALK_W'(TABLE_ENTRIES));
    assign walk_done   = (state_reg == ST_WALK) && (walk_cnt_reg == WALK_W'(TABLE_ENTRIES));
    assign active      = table_ready_reg && tracking_reg;
    assign in_op       = op_t'(s_tuser[OP_W-1:0]);
    assign in_handle   = s_tdata[WORD_W-1:0];

    // Classify the incoming word
    always_comb
    begin
        kind_next = K_IGNORE;
        unique case (in_op)
            OP_CLEAR:
            begin
                kind_next = table_ready_reg ? K_IGNORE : K_CLEAR;
            end
            OP_SCAN:
            begin
                kind_next = active ? K_SCAN : K_IGNORE;
            end
            OP_ALLOC:
            begin
                kind_next = (active && in_handle != '0) ? K_ALLOC : K_IGNORE;
            end
            OP_RELEASE:
            begin
                kind_next = (active && in_handle != '0) ? K_RELEASE : K_IGNORE;
            end
            default:
            begin
                kind_next = K_IGNORE;
            end
        endcase
    end

    // Split the entry read back from memory
    assign rd_handle = rd_data_reg[WORD_W-1:0];
    assign rd_bytes  = rd_data_reg[2*WORD_W-1:WORD_W];
    assign rd_stamp  = rd_data_reg[3*WORD_W-1:2*WORD_W];
    assign rd_valid  = valid_reg[rd_idx_reg];
    assign rd_age    = now_reg - rd_stamp;
    assign sum_wide  = {1'b0, leak_sum_reg} + {1'b0, rd_bytes};

    // Slot written by an allocation: lowest free, else the oldest
    assign wr_slot = free_found_reg ? free_idx_reg : best_idx_reg;
    assign mem_we  = finish_fire && (kind_reg == K_ALLOC);

    // Record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[wr_slot] <= {now_reg, bytes_reg, handle_reg};
        end
        if (walk_issue)
        begin
            rd_data_reg <= entry_mem[walk_cnt_reg[IDX_W-1:0]];
        end
    end

    // Hold the payload of the accepted word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            handle_reg <= in_handle;
            bytes_reg  <= s_tdata[2*WORD_W-1:WORD_W];
            now_reg    <= s_tdata[3*WORD_W-1:2*WORD_W];
        end
    end

    // Sequencer, table control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kind_reg        <= K_IGNORE;
            walk_cnt_reg    <= '0;
            rd_pend_reg     <= 1'b0;
            rd_idx_reg      <= '0;
            valid_reg       <= '0;
            live_reg        <= '0;
            table_ready_reg <= 1'b0;
            tracking_reg    <= 1'b1;
            age_limit_reg   <= AGE_LIMIT_RESET;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            best_vld_reg    <= 1'b0;
            best_idx_reg    <= '0;
            best_stamp_reg  <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            leak_cnt_reg    <= '0;
            leak_sum_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            // Register writes
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_AGE_LIMIT: age_limit_reg <= cfg_data[WORD_W-1:0];
                    REG_TRACKING:  tracking_reg  <= cfg_data[0];
                    default:       tracking_reg  <= tracking_reg;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (out_valid_reg && m_tready && !finish_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_pend_reg <= walk_issue;
            if (walk_issue)
            begin
                rd_idx_reg   <= walk_cnt_reg[IDX_W-1:0];
                walk_cnt_reg <= walk_cnt_reg + WALK_W'(1);
            end

            // Fold in the entry read in the previous cycle
            if (rd_pend_reg)
            begin
                if (!rd_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= rd_idx_reg;
                end
                if (rd_valid && (!best_vld_reg || rd_stamp < best_stamp_reg))
                begin
                    best_vld_reg   <= 1'b1;
                    best_idx_reg   <= rd_idx_reg;
                    best_stamp_reg <= rd_stamp;
                end
                if (rd_valid && rd_handle == handle_reg && !match_found_reg)
                begin
                    match_found_reg <= 1'b1;
                    match_idx_reg   <= rd_idx_reg;
                end
                if (rd_valid && rd_age > age_limit_reg)
                begin
                    leak_cnt_reg <= leak_cnt_reg + CNT_OUT_W'(1);
                    leak_sum_reg <= sum_wide[WORD_W] ? '1 : sum_wide[WORD_W-1:0];
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        kind_reg        <= kind_next;
                        walk_cnt_reg    <= '0;
                        free_found_reg  <= 1'b0;
                        best_vld_reg    <= 1'b0;
                        match_found_reg <= 1'b0;
                        leak_cnt_reg    <= '0;
                        leak_sum_reg    <= '0;
                        if (kind_next == K_ALLOC || kind_next == K_RELEASE ||
                            kind_next == K_SCAN)
                        begin
                            state_reg <= ST_WALK;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_WALK:
                begin
                    if (walk_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (finish_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        unique case (kind_reg)
                            K_CLEAR:
                            begin
                                valid_reg       <= '0;
                                live_reg        <= '0;
                                table_ready_reg <= 1'b1;
                                out_data_reg    <= M_DATA_W'(3'b001);
                            end
                            K_ALLOC:
                            begin
                                valid_reg[wr_slot] <= 1'b1;
                                if (free_found_reg)
                                begin
                                    live_reg <= live_reg + LIVE_W'(1);
                                end
                                out_data_reg <= M_DATA_W'({
                                    CNT_OUT_W'(live_reg + LIVE_W'(free_found_reg)),
                                    1'b0, !free_found_reg, 1'b1});
                            end
                            K_RELEASE:
                            begin
                                if (match_found_reg)
                                begin
                                    valid_reg[match_idx_reg] <= 1'b0;
                                    live_reg <= live_reg - LIVE_W'(1);
                                end
                                out_data_reg <= M_DATA_W'({
                                    CNT_OUT_W'(live_reg - LIVE_W'(match_found_reg)),
                                    match_found_reg, 1'b0, 1'b1});
                            end
                            K_SCAN:
                            begin
                                out_data_reg <= M_DATA_W'({leak_sum_reg, leak_cnt_reg,
                                    CNT_OUT_W'(live_reg), 3'b001});
                            end
                            default:
                            begin
                                out_data_reg <= M_DATA_W'({CNT_OUT_W'(live_reg), 3'b000});
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* bench/allocation_tracker_leak_scan_tb.sv */
// Self-checking bench for the allocation tracker: mirrors the table, checks every word.
module allocation_tracker_leak_scan_tb;
    import alts_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_SIZE   = 24;

    // Result word, accepted in bit 0
    typedef struct packed {
        logic [31:0] leak_bytes;
        logic [6:0]  leak_count;
        logic [6:0]  live_records;
        logic        found;
        logic        evicted;
        logic        accepted;
    } tracker_result_t;

    // Mirror of the record table and queue of results still owed by the block
    class tracker_mirror;
        bit [31:0]       rec_handle [TABLE_ENTRIES];
        bit [31:0]       rec_bytes  [TABLE_ENTRIES];
        bit [31:0]       rec_stamp  [TABLE_ENTRIES];
        bit              rec_live   [TABLE_ENTRIES];
        bit [6:0]        live_total    = '0;
        bit              table_enabled = 1'b0;
        bit [31:0]       age_limit     = AGE_LIMIT_RESET;
        bit              tracking      = 1'b1;
        tracker_result_t owed_results[$];
        int              failures      = 0;

        function void write_register(cfg_reg_t idx, bit [31:0] value);
            case (idx)
                REG_AGE_LIMIT: age_limit = value;
                REG_TRACKING:  tracking  = value[0];
                default:       ;
            endcase
        endfunction

        // Work out the result of one accepted word and update the table
        function void note_request(op_t op, bit [31:0] handle, bit [31:0] size,
                                   bit [31:0] now);
            tracker_result_t r;
            int              slot;
            bit [31:0]       age;
            bit [32:0]       sum;
            bit [6:0]        count;
            r = '0;
            if (op == OP_CLEAR)
            begin
                if (!table_enabled)
                begin
                    foreach (rec_live[k])
                        rec_live[k] = 1'b0;
                    live_total    = '0;
                    table_enabled = 1'b1;
                    r.accepted    = 1'b1;
                end
            end
            else if (table_enabled && tracking)
            begin
                if (op == OP_SCAN)
                begin
                    sum   = '0;
                    count = '0;
                    for (int k = 0; k < TABLE_ENTRIES; k++)
                    begin
                        age = now - rec_stamp[k];
                        if (rec_live[k] && age > age_limit)
                        begin
                            count = count + 1'b1;
                            sum   = sum + rec_bytes[k];
                            if (sum[32])
                                sum = 33'h0_FFFF_FFFF;
                        end
                    end
                    r.accepted   = 1'b1;
                    r.leak_count = count;
                    r.leak_bytes = sum[31:0];
                end
                else if (handle != '0)
                begin
                    r.accepted = 1'b1;
                    if (op == OP_ALLOC)
                    begin
                        slot = -1;
                        for (int k = 0; k < TABLE_ENTRIES && slot < 0; k++)
                            if (!rec_live[k])
                                slot = k;
                        // Table full: overwrite the oldest raw stamp, lowest index on ties
                        if (slot < 0)
                        begin
                            slot = 0;
                            for (int k = 1; k < TABLE_ENTRIES; k++)
                                if (rec_stamp[k] < rec_stamp[slot])
                                    slot = k;
                            r.evicted = 1'b1;
                        end
                        else
                        begin
                            live_total = live_total + 1'b1;
                        end
                        rec_handle[slot] = handle;
                        rec_bytes[slot]  = size;
                        rec_stamp[slot]  = now;
                        rec_live[slot]   = 1'b1;
                    end
                    else
                    begin
                        for (int k = 0; k < TABLE_ENTRIES && !r.found; k++)
                            if (rec_live[k] && rec_handle[k] == handle)
                            begin
                                rec_live[k] = 1'b0;
                                live_total  = live_total - 1'b1;
                                r.found     = 1'b1;
                            end
                    end
                end
            end
            r.live_records = live_total;
            owed_results.push_back(r);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
                failures++;
            end
        endfunction

        // Compare one taken result word with the oldest owed result
        function void check_result(logic [M_DATA_W-1:0] word);
            tracker_result_t want;
            tracker_result_t got;
            got = word[$bits(tracker_result_t)-1:0];
            if (owed_results.size() == 0)
            begin
                $display("%0t: result word expected none, got %0h", $time, word);
                failures++;
                return;
            end
            want = owed_results.pop_front();
            match_field("accepted", 32'(want.accepted), 32'(got.accepted));
            match_field("evicted", 32'(want.evicted), 32'(got.evicted));
            match_field("found", 32'(want.found), 32'(got.found));
            match_field("live_records", 32'(want.live_records), 32'(got.live_records));
            match_field("leak_count", 32'(want.leak_count), 32'(got.leak_count));
            match_field("leak_bytes", want.leak_bytes, got.leak_bytes);
            match_field("zero pad", 32'd0, 32'(word[M_DATA_W-1:$bits(tracker_result_t)]));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tracker_mirror mirror;
    int            send_idle_pct = 7;
    int            recv_idle_pct = 51;
    int            cycle_count   = 0;
    bit [31:0]     clock_ms;
    bit [31:0]     handle_pool [POOL_SIZE];

    allocation_tracker_leak_scan i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Check every result word taken
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_result(m_tdata);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one word, idling first at random; valid stays high on return
    task automatic push_request(op_t op, bit [31:0] handle, bit [31:0] size, bit [31:0] now);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {now, size, handle};
        do
            @(posedge clk);
        while (!s_tready);
        mirror.note_request(op, handle, size, now);
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic settle();
        s_tvalid <= 1'b0;
        while (mirror.owed_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, bit [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror.write_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Random word: mostly pooled handles and a slowly advancing, wrapping clock
    task automatic random_request(int alloc_pct, int release_pct);
        int        pick;
        op_t       op;
        bit [31:0] handle;
        bit [31:0] size;
        bit [31:0] now;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
            op = OP_ALLOC;
        else if (pick < alloc_pct + release_pct)
            op = OP_RELEASE;
        else if (pick < 97)
            op = OP_SCAN;
        else
            op = OP_CLEAR;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            handle = '0;
        else if (pick < 24)
            handle = $urandom;
        else
            handle = handle_pool[$urandom_range(0, POOL_SIZE - 1)];
        size = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 4096);
        clock_ms = clock_ms + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 40000)
                                                             : $urandom_range(0, 300));
        now = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms;
        push_request(op, handle, size, now);
    endtask

    initial
    begin
        int alloc_pct;
        int release_pct;
        mirror    = new;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        clock_ms  = 32'hFFFE_0000 + $urandom_range(0, 65535);
        foreach (handle_pool[k])
        begin
            handle_pool[k] = $urandom;
            if (handle_pool[k] == '0)
                handle_pool[k] = 32'd1;
        end
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Table not yet enabled: everything but a clear is ignored
        push_request(OP_ALLOC, 32'hA5A5_0001, 32'd16, 32'd10);
        push_request(OP_RELEASE, 32'hA5A5_0001, 32'd0, 32'd20);
        push_request(OP_SCAN, 32'd0, 32'd0, 32'd100000);
        settle();
        // Tracking off: a first clear still enables the table
        write_reg(REG_TRACKING, 32'd0);
        push_request(OP_ALLOC, 32'hA5A5_0002, 32'd16, 32'd30);
        push_request(OP_CLEAR, 32'd0, 32'd0, 32'd40);
        push_request(OP_SCAN, 32'd0, 32'd0, 32'd50);
        settle();
        write_reg(REG_TRACKING, 32'd1);
        // Repeated clear, null handles, field extremes, duplicates, missed release
        push_request(OP_CLEAR, 32'd0, 32'd0, 32'd60);
        push_request(OP_ALLOC, 32'd0, 32'd99, 32'd70);
        push_request(OP_RELEASE, 32'd0, 32'd0, 32'd80);
        push_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        push_request(OP_ALLOC, 32'd1, 32'd0, 32'hFFFF_FFFF);
        push_request(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd50);
        push_request(OP_RELEASE, 32'hFFFF_FFFF, 32'd0, 32'd60);
        push_request(OP_RELEASE, 32'h1234_5678, 32'd0, 32'd70);
        push_request(OP_ALLOC, 32'd2, 32'h8000_0000, 32'd1);
        // Age equal to the limit is no leak; then a saturating sum
        push_request(OP_SCAN, 32'd0, 32'd0, 32'd30001);
        push_request(OP_SCAN, 32'd0, 32'd0, 32'd40000);
        settle();
        write_reg(REG_AGE_LIMIT, 32'd0);
        push_request(OP_SCAN, 32'd0, 32'd0, 32'd50);
        settle();
        write_reg(REG_AGE_LIMIT, 32'hFFFF_FFFF);
        push_request(OP_SCAN, 32'd0, 32'd0, 32'hFFFF_FFFF);

        // Random phases, each with its own idling, mix and age limit
        for (int ph = 0; ph < 3; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 51;
                    alloc_pct     = 60;
                    release_pct   = 22;
                    write_reg(REG_AGE_LIMIT, $urandom_range(100, 5000));
                end
                1:
                begin
                    // Short burst with tracking off: all ignored
                    write_reg(REG_TRACKING, 32'd0);
                    repeat (12) random_request(40, 30);
                    settle();
                    write_reg(REG_TRACKING, 32'd1);
                    send_idle_pct = 51;
                    recv_idle_pct = 7;
                    alloc_pct     = 30;
                    release_pct   = 50;
                    write_reg(REG_AGE_LIMIT, 32'd0);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    alloc_pct     = 55;
                    release_pct   = 27;
                    write_reg(REG_AGE_LIMIT, $urandom_range(1000, 20000));
                end
            endcase
            repeat (400) random_request(alloc_pct, release_pct);
        end

        // Drain, then watch for stray result words
        settle();
        repeat (TABLE_ENTRIES + 8) @(posedge clk);
        if (mirror.failures == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* allocation_tracker_leak_scan.f */
src/alts_pkg.sv
src/allocation_tracker_leak_scan.sv
bench/allocation_tracker_leak_scan_tb.sv
